// File: rtl/core/tlsched_pkg.sv
// Package with shared types and constants for the two-level thread scheduler.
package tlsched_pkg;

  localparam int unsigned SLOTS_DEFAULT = 16;
  localparam int unsigned REM_W = 24;
  localparam logic [7:0] QUANTUM_RESET = 8'd20;

  localparam logic ADDR_RR_QUANTUM = 1'b0;

  localparam logic [1:0] STATUS_CREATED = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_TICK    = 2'd2;

  localparam logic MODE_CREATE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  localparam logic [1:0] SLOT_FREE  = 2'd0;
  localparam logic [1:0] SLOT_READY = 2'd1;
  localparam logic [1:0] SLOT_RUN   = 2'd2;
  localparam logic [1:0] SLOT_DONE  = 2'd3;

  typedef struct packed {
    logic            mode;
    logic            priority_req;
    logic [REM_W-1:0] exec_ticks;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] create_status;
    logic [3:0] new_id;
    logic [3:0] running_id;
    logic       switched;
    logic       finished;
    logic [3:0] finished_id;
    logic       all_done;
  } out_beat_t;

endpackage

// File: rtl/core/two_level_sjf_rr_thread_scheduler.sv
// Top level of the two-level (sorted high, round-robin low) thread scheduler.
// One input beat at a time is processed; the input stalls until that beat's
// result has been placed in the output register. A tick may keep the running
// thread or take the next one from the sorted queue or the FIFO, and a high
// create may preempt a low thread. A high create that joins the sorted queue
// scans the queued entries for its place and moves each later entry up by
// one; taking the next thread from the sorted queue shifts that queue down by
// one entry. Remaining time lives in a one-port memory with a registered
// read; the sorted queue and the FIFO share a second memory. Per-slot state
// and priority are flip-flops. The result beat sits in an output register, so
// the next input beat is accepted while that result still waits; its own
// result is then held back until the register frees.
module two_level_sjf_rr_thread_scheduler #(
  parameter int unsigned SLOTS = tlsched_pkg::SLOTS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tlsched_pkg::in_beat_t in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tlsched_pkg::out_beat_t out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned RW = tlsched_pkg::REM_W;
  localparam int unsigned QDEPTH = 2 * (1 << IW);

  localparam logic [1:0] ST_FREE  = tlsched_pkg::SLOT_FREE;
  localparam logic [1:0] ST_READY = tlsched_pkg::SLOT_READY;
  localparam logic [1:0] ST_RUN   = tlsched_pkg::SLOT_RUN;
  localparam logic [1:0] ST_DONE  = tlsched_pkg::SLOT_DONE;

  typedef enum logic [4:0] {
    S_IDLE, S_CREATE, S_RDRUN, S_WTRUN, S_PREEMPT, S_TICK_RD, S_TICK_WT, S_TICK,
    S_INS_RD, S_INS_WT, S_INS_CMP, S_SHIFT_RD, S_SHIFT_WR, S_PICK, S_POP_RD,
    S_POP_WT, S_POP_WR, S_OUT
  } state_t;

  state_t state;

  // Configuration register.
  logic [7:0] rr_quantum;
  assign pready = 1'b1;
  assign prdata = {24'd0, rr_quantum};

  // Per-slot flags.
  logic [1:0]       slot_state [SLOTS];
  logic [SLOTS-1:0] slot_priority;

  // Remaining-time memory.
  logic [RW-1:0] rem_mem [SLOTS];
  logic [IW-1:0] rem_addr;
  logic          rem_we;
  logic [RW-1:0] rem_wdata;
  logic [RW-1:0] rem_rdata;

  // Queue memory: the sorted queue (kept in order from index 0) in the lower
  // half, the round-robin FIFO in the upper half.
  logic [IW-1:0] q_mem [QDEPTH];
  logic [IW:0]   q_addr;
  logic          q_we;
  logic [IW-1:0] q_wdata;
  logic [IW-1:0] q_rdata;
  logic [CW-1:0] sjf_count;
  logic [IW-1:0] rr_head;
  logic [CW-1:0] rr_count;

  always_ff @(posedge clk) begin
    if (rem_we) rem_mem[rem_addr] <= rem_wdata;
    rem_rdata <= rem_mem[rem_addr];
    if (q_we) q_mem[q_addr] <= q_wdata;
    q_rdata <= q_mem[q_addr];
  end

  // Scheduler registers.
  logic [IW-1:0] running_slot;
  logic [7:0]    slice_left;
  logic          idle_flag;
  logic [IW-1:0] old_run;
  logic          old_idle;
  logic          cur_pr;
  logic [RW-1:0] cur_ex;
  logic [IW-1:0] new_slot;
  logic [1:0]    status;
  logic          fin;
  logic [IW-1:0] fin_id;
  logic [IW-1:0] ins_id;     // slot being inserted into the sorted queue
  logic [RW-1:0] ins_key;
  logic [CW-1:0] walk;       // insertion scan / shift position
  logic [CW-1:0] ins_pos;
  logic          after_ins_start; // start new_slot once the insert finishes
  logic          run_is_high;
  logic [RW-1:0] run_rem;

  // First free slot search over flags (slot 0 never free).
  logic          free_found;
  logic [IW-1:0] free_slot;
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int k = SLOTS - 1; k >= 1; k--) begin
      if (slot_state[k] == ST_FREE) begin
        free_found = 1'b1;
        free_slot  = IW'(k);
      end
    end
  end

  logic [7:0] quantum_eff;
  assign quantum_eff = (rr_quantum == 8'd0) ? 8'd1 : rr_quantum;

  // FIFO tail: head plus count, wrapped at SLOTS.
  logic [CW:0]   rr_sum;
  logic [IW-1:0] rr_tail;
  assign rr_sum  = (CW+1)'(rr_head) + (CW+1)'(rr_count);
  assign rr_tail = (rr_sum >= (CW+1)'(SLOTS)) ? IW'(rr_sum - (CW+1)'(SLOTS)) : IW'(rr_sum);

  assign in_stall = (state != S_IDLE);

  // Memory port control.
  always_comb begin
    rem_addr  = running_slot;
    rem_we    = 1'b0;
    rem_wdata = cur_ex;
    q_addr    = {1'b1, rr_tail};
    q_we      = 1'b0;
    q_wdata   = running_slot;
    unique case (state)
      S_CREATE: begin
        rem_addr = free_slot;
        rem_we   = free_found;
        rem_wdata = cur_ex;
        q_wdata  = free_slot;
        q_we     = free_found && !idle_flag && !cur_pr;
      end
      S_RDRUN, S_TICK_RD: rem_addr = running_slot;
      S_PREEMPT: begin
        q_wdata = running_slot;
        q_we    = !run_is_high;
      end
      S_TICK: begin
        rem_addr  = running_slot;
        rem_we    = (running_slot != '0);
        rem_wdata = (rem_rdata <= RW'(1)) ? '0 : rem_rdata - RW'(1);
        q_wdata   = running_slot;
        q_we      = !(running_slot != '0 && rem_rdata <= RW'(1)) &&
                    !slot_priority[running_slot] && slice_left <= 8'd1;
      end
      S_INS_RD: q_addr = {1'b0, walk[IW-1:0]};
      S_INS_WT: begin
        q_addr   = {1'b0, walk[IW-1:0]};
        rem_addr = q_rdata;
      end
      S_SHIFT_RD: q_addr = {1'b0, IW'(walk - CW'(1))};
      S_SHIFT_WR: begin
        q_addr  = {1'b0, walk[IW-1:0]};
        q_we    = 1'b1;
        q_wdata = (walk == ins_pos) ? ins_id : q_rdata;
      end
      // Only one queue is read here; the counts already tell which one.
      S_PICK: q_addr = (sjf_count != '0) ? '0 : {1'b1, rr_head};
      S_POP_RD, S_POP_WT: q_addr = {1'b0, IW'(walk + CW'(1))};
      S_POP_WR: begin
        q_addr  = {1'b0, walk[IW-1:0]};
        q_we    = 1'b1;
        q_wdata = q_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rr_quantum    <= tlsched_pkg::QUANTUM_RESET;
      slice_left    <= tlsched_pkg::QUANTUM_RESET;
      for (int k = 0; k < SLOTS; k++) slot_state[k] <= (k == 0) ? ST_RUN : ST_FREE;
      slot_priority <= '0;
      running_slot  <= '0;
      idle_flag     <= 1'b0;
      sjf_count     <= '0;
      rr_head       <= '0;
      rr_count      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == tlsched_pkg::ADDR_RR_QUANTUM)
        rr_quantum <= pwdata[7:0];
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            old_run  <= running_slot;
            old_idle <= idle_flag;
            cur_pr   <= in_data.priority_req;
            cur_ex   <= in_data.exec_ticks;
            fin      <= 1'b0;
            fin_id   <= '0;
            new_slot <= '0;
            after_ins_start <= 1'b0;
            if (in_data.mode == tlsched_pkg::MODE_CREATE) begin
              state <= S_CREATE;
            end else begin
              status <= tlsched_pkg::STATUS_TICK;
              state  <= idle_flag ? S_OUT : S_TICK_RD;
            end
          end
        end
        S_CREATE: begin
          if (!free_found) begin
            status <= tlsched_pkg::STATUS_FULL;
            state  <= S_OUT;
          end else begin
            status <= tlsched_pkg::STATUS_CREATED;
            new_slot <= free_slot;
            slot_priority[free_slot] <= cur_pr;
            if (idle_flag) begin
              running_slot <= free_slot;
              slot_state[free_slot] <= ST_RUN;
              slice_left <= quantum_eff;
              idle_flag <= 1'b0;
              state <= S_OUT;
            end else if (cur_pr) begin
              slot_state[free_slot] <= ST_READY;
              run_is_high <= slot_priority[running_slot];
              state <= S_RDRUN;
            end else begin
              slot_state[free_slot] <= ST_READY;
              rr_count <= rr_count + CW'(1);
              state <= S_OUT;
            end
          end
        end
        S_RDRUN: state <= S_WTRUN;
        S_WTRUN: begin
          run_rem <= rem_rdata;
          state   <= S_PREEMPT;
        end
        S_PREEMPT: begin
          if (!run_is_high) begin
            rr_count <= rr_count + CW'(1);
            slot_state[running_slot] <= ST_READY;
            running_slot <= new_slot;
            slot_state[new_slot] <= ST_RUN;
            slice_left <= quantum_eff;
            state <= S_OUT;
          end else if (run_rem > cur_ex) begin
            ins_id  <= running_slot;
            ins_key <= run_rem;
            after_ins_start <= 1'b1;
            walk    <= '0;
            ins_pos <= sjf_count;
            state   <= (sjf_count == '0) ? S_SHIFT_WR : S_INS_RD;
          end else begin
            ins_id  <= new_slot;
            ins_key <= cur_ex;
            walk    <= '0;
            ins_pos <= sjf_count;
            state   <= (sjf_count == '0) ? S_SHIFT_WR : S_INS_RD;
          end
        end
        // Scan the sorted queue for the first entry with a larger key.
        S_INS_RD: state <= S_INS_WT;
        S_INS_WT: state <= S_INS_CMP;
        S_INS_CMP: begin
          if (rem_rdata > ins_key || walk + CW'(1) == sjf_count) begin
            ins_pos <= (rem_rdata > ins_key) ? walk : sjf_count;
            walk    <= sjf_count;
            state   <= (sjf_count == ((rem_rdata > ins_key) ? walk : sjf_count))
                       ? S_SHIFT_WR : S_SHIFT_RD;
          end else begin
            walk  <= walk + CW'(1);
            state <= S_INS_RD;
          end
        end
        // Shift entries up from the tail, then drop the inserted id in place.
        S_SHIFT_RD: state <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          if (walk == ins_pos) begin
            sjf_count <= sjf_count + CW'(1);
            slot_state[ins_id] <= ST_READY;
            if (after_ins_start) begin
              running_slot <= new_slot;
              slot_state[new_slot] <= ST_RUN;
              slice_left <= quantum_eff;
            end
            state <= S_OUT;
          end else begin
            walk  <= walk - CW'(1);
            state <= (walk - CW'(1) == ins_pos) ? S_SHIFT_WR : S_SHIFT_RD;
          end
        end
        S_TICK_RD: state <= S_TICK_WT;
        S_TICK_WT: state <= S_TICK;
        S_TICK: begin
          if (running_slot != '0 && rem_rdata <= RW'(1)) begin
            slot_state[running_slot] <= ST_DONE;
            fin    <= 1'b1;
            fin_id <= running_slot;
            state  <= S_PICK;
          end else if (!slot_priority[running_slot]) begin
            if (slice_left <= 8'd1) begin
              rr_count <= rr_count + CW'(1);
              slot_state[running_slot] <= ST_READY;
              state <= S_PICK;
            end else begin
              slice_left <= slice_left - 8'd1;
              state <= S_OUT;
            end
          end else begin
            state <= S_OUT;
          end
        end
        // Sorted queue head first (read data arrives next cycle), else FIFO.
        S_PICK: begin
          if (sjf_count != '0) begin
            walk  <= '0;
            state <= S_POP_RD;
          end else if (rr_count != '0) begin
            state <= S_POP_WT;
            walk  <= '1;
          end else begin
            idle_flag <= 1'b1;
            state <= S_OUT;
          end
        end
        S_POP_RD: begin
          // q_rdata now holds the head entry.
          running_slot <= q_rdata;
          slot_state[q_rdata] <= ST_RUN;
          slice_left <= quantum_eff;
          idle_flag <= 1'b0;
          state <= (sjf_count == CW'(1)) ? S_POP_WR : S_POP_WT;
        end
        S_POP_WT: begin
          if (walk == '1) begin
            // FIFO head read data is valid here.
            running_slot <= q_rdata;
            slot_state[q_rdata] <= ST_RUN;
            slice_left <= quantum_eff;
            idle_flag <= 1'b0;
            rr_head <= (rr_head == IW'(SLOTS - 1)) ? '0 : rr_head + IW'(1);
            rr_count <= rr_count - CW'(1);
            state <= S_OUT;
          end else begin
            state <= S_POP_WR;
          end
        end
        S_POP_WR: begin
          if (walk + CW'(2) >= sjf_count) begin
            sjf_count <= sjf_count - CW'(1);
            state <= S_OUT;
          end else begin
            walk  <= walk + CW'(1);
            state <= S_POP_WT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data.create_status <= status;
            out_data.new_id      <= 4'(new_slot);
            out_data.running_id  <= idle_flag ? 4'd0 : 4'(running_slot);
            out_data.switched    <= (idle_flag != old_idle) || (running_slot != old_run);
            out_data.finished    <= fin;
            out_data.finished_id <= 4'(fin_id);
            out_data.all_done    <= idle_flag;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
